// ===== hdl/serial_frame_parser_unpack_unit_assert.svh =====
// assertion macros for the serial frame parser checker
// expects clk and rst_n in the scope where a macro is used
`ifndef SERIAL_FRAME_PARSER_UNPACK_UNIT_ASSERT_SVH
`define SERIAL_FRAME_PARSER_UNPACK_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SFP_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("sfp check failed");

// next-cycle implication, checked out of reset
`define SFP_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("sfp check failed");

// behavior right after a reset cycle
`define SFP_ASSERT_RST(lbl, post) \
  lbl: assert property (@(posedge clk) !rst_n |=> (post)) \
    else $error("sfp reset check failed");

`endif

// ===== hdl/sfp_pkg.sv =====
`timescale 1ns / 1ps
// types and constants shared by the serial frame parser modules
// no dependencies
package sfp_pkg;

  localparam int BODY_LEN = 11;
  localparam int NUM_VALUES = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL_FIRST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL_SECOND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 3'd4;

  // register reset values
  localparam logic [7:0] RST_HEADER_FIRST = 8'hBB;
  localparam logic [7:0] RST_HEADER_SECOND = 8'h77;
  localparam logic [7:0] RST_TAIL_FIRST = 8'hCC;
  localparam logic [7:0] RST_TAIL_SECOND = 8'hEE;
  localparam logic [15:0] RST_TIMEOUT = 16'd1000;

  localparam logic [3:0] NIBBLE_MASK = 4'hF;
  localparam logic [15:0] IDLE_MAX = 16'hFFFF;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef logic [BODY_LEN-1:0][7:0] body_t;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] value_one;
    logic signed [15:0] value_two;
    logic signed [15:0] value_three;
    logic signed [15:0] value_four;
    logic signed [15:0] value_five;
    logic [3:0]         count_a;
    logic [3:0]         count_b;
  } held_t;

  typedef struct packed {
    logic signed [15:0] value_one;
    logic signed [15:0] value_two;
    logic signed [15:0] value_three;
    logic signed [15:0] value_four;
    logic signed [15:0] value_five;
    logic [3:0]         count_a;
    logic [3:0]         count_b;
    logic               frame_done;
    logic               frame_accepted;
    logic               link_alive;
  } out_item_t;

endpackage

// ===== hdl/sfp_unpack.sv =====
`timescale 1ns / 1ps
// unpacks the stored frame body into five values and two nibble counts
// depends on sfp_pkg
module sfp_unpack (
  input  sfp_pkg::body_t body,
  output sfp_pkg::held_t held
);
  import sfp_pkg::*;

  logic [3:0]  nib_hi;
  logic [3:0]  nib_lo;
  logic        ok;
  logic [NUM_VALUES-1:0][15:0] vals;

  assign nib_hi = body[BODY_LEN-1][7:4] & NIBBLE_MASK;
  assign nib_lo = body[BODY_LEN-1][3:0] & NIBBLE_MASK;
  assign ok = (nib_hi >= 4'd1) && (nib_hi <= 4'd3) && (nib_lo >= 4'd1) && (nib_lo <= 4'd3);

  // low byte first, any bad nibble zeroes everything
  always_comb begin
    for (int k = 0; k < NUM_VALUES; k++) begin
      vals[k] = ok ? {body[2*k+1], body[2*k]} : 16'd0;
    end
  end

  assign held.value_one   = vals[0];
  assign held.value_two   = vals[1];
  assign held.value_three = vals[2];
  assign held.value_four  = vals[3];
  assign held.value_five  = vals[4];
  assign held.count_a     = ok ? nib_hi : 4'd0;
  assign held.count_b     = ok ? nib_lo : 4'd0;

endmodule

// ===== hdl/serial_frame_parser_unpack_unit.sv =====
`timescale 1ns / 1ps
// Fixed-length serial frame parser with link watchdog.
// Input channel (in_valid/in_ready/in_data): one request per received byte
// (action 0) or timer tick (action 1). Each request yields exactly one result
// on the output channel (out_valid/out_ready/out_data) with the held values,
// the two counts, frame_done, frame_accepted and the link flag after it.
// A frame is two header bytes, 11 body bytes and two tail bytes; the body is
// unpacked when the second tail byte matches.
// A request is held in the input register and its result is presented from
// the result register that follows it. Throughput: one request per cycle
// unless the receiver stalls; the parser state update is a single pass of
// compare and select logic between the two registers.
// Reset (rst_n low, synchronous) empties both registers, returns the parser
// to header hunt, clears held values, link flag and idle counter, and loads
// the configuration registers with their defaults.
// When the receiver stalls, the result holds and the input register keeps
// one more request; in_ready drops once both are full.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata while idle.
module serial_frame_parser_unpack_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  sfp_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sfp_pkg::out_item_t                  out_data,
  input  logic                                cfg_wr_en,
  input  logic [sfp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sfp_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import sfp_pkg::*;

  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_HEAD2 = 3'd1;
  localparam logic [2:0] PH_BODY  = 3'd2;
  localparam logic [2:0] PH_TAIL1 = 3'd3;
  localparam logic [2:0] PH_TAIL2 = 3'd4;

  logic [7:0]  hdr1_r, hdr2_r, tail1_r, tail2_r;
  logic [15:0] timeout_r;

  logic        s1_valid_r, s1_valid_nxt;
  in_item_t    s1_data_r;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  idx_r, idx_nxt;
  body_t       body_r;
  held_t       held_r, held_nxt;
  held_t       unpacked;
  logic        alive_r, alive_nxt;
  logic [15:0] idle_r, idle_nxt;
  logic        done, accepted, body_wr;

  logic out_free, in_fire, fire;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || out_free;
  assign in_fire  = in_valid && in_ready;
  assign fire     = s1_valid_r && out_free;

  sfp_unpack u_unpack (
    .body (body_r),
    .held (unpacked)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr1_r    <= RST_HEADER_FIRST;
      hdr2_r    <= RST_HEADER_SECOND;
      tail1_r   <= RST_TAIL_FIRST;
      tail2_r   <= RST_TAIL_SECOND;
      timeout_r <= RST_TIMEOUT;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_HEADER_FIRST:  hdr1_r    <= cfg_wdata[7:0];
        CFG_HEADER_SECOND: hdr2_r    <= cfg_wdata[7:0];
        CFG_TAIL_FIRST:    tail1_r   <= cfg_wdata[7:0];
        CFG_TAIL_SECOND:   tail2_r   <= cfg_wdata[7:0];
        CFG_TIMEOUT:       timeout_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // parser and watchdog update for the request in the input register
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    held_nxt  = held_r;
    alive_nxt = alive_r;
    idle_nxt  = idle_r;
    done      = 1'b0;
    accepted  = 1'b0;
    body_wr   = 1'b0;
    if (fire) begin
      if (s1_data_r.action == ACT_TICK) begin
        idle_nxt = (idle_r == IDLE_MAX) ? idle_r : idle_r + 16'd1;
        if (idle_nxt >= timeout_r) begin
          alive_nxt = 1'b0;
        end
      end else begin
        idle_nxt = 16'd0;
        unique case (phase_r)
          PH_HUNT: begin
            if (s1_data_r.rx_byte == hdr1_r) phase_nxt = PH_HEAD2;
          end
          PH_HEAD2: begin
            if (s1_data_r.rx_byte == hdr2_r) begin
              idx_nxt   = 4'd0;
              phase_nxt = PH_BODY;
            end else begin
              phase_nxt = PH_HUNT;
            end
          end
          PH_BODY: begin
            body_wr = (idx_r < 4'(BODY_LEN));
            idx_nxt = idx_r + 4'd1;
            if (idx_nxt >= 4'(BODY_LEN)) phase_nxt = PH_TAIL1;
          end
          PH_TAIL1: begin
            phase_nxt = (s1_data_r.rx_byte == tail1_r) ? PH_TAIL2 : PH_HUNT;
          end
          PH_TAIL2: begin
            if (s1_data_r.rx_byte == tail2_r) begin
              held_nxt = unpacked;
              accepted = 1'b1;
            end
            phase_nxt = PH_HUNT;
            idx_nxt   = 4'd0;
            alive_nxt = 1'b1;
            done      = 1'b1;
          end
          default: begin
            phase_nxt = PH_HUNT;
            idx_nxt   = 4'd0;
          end
        endcase
      end
    end
  end

  always_comb begin
    out_data_nxt.value_one      = held_nxt.value_one;
    out_data_nxt.value_two      = held_nxt.value_two;
    out_data_nxt.value_three    = held_nxt.value_three;
    out_data_nxt.value_four     = held_nxt.value_four;
    out_data_nxt.value_five     = held_nxt.value_five;
    out_data_nxt.count_a        = held_nxt.count_a;
    out_data_nxt.count_b        = held_nxt.count_b;
    out_data_nxt.frame_done     = done;
    out_data_nxt.frame_accepted = accepted;
    out_data_nxt.link_alive     = alive_nxt;
  end

  assign s1_valid_nxt  = in_fire ? 1'b1 : (fire ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_HUNT;
      idx_r       <= 4'd0;
      held_r      <= '0;
      alive_r     <= 1'b0;
      idle_r      <= 16'd0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      held_r      <= held_nxt;
      alive_r     <= alive_nxt;
      idle_r      <= idle_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire) s1_data_r <= in_data;
    if (fire) out_data_r <= out_data_nxt;
    if (fire && body_wr) body_r[idx_r] <= s1_data_r.rx_byte;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/sfp_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for serial_frame_parser_unpack_unit, bound to the top
// depends on sfp_pkg and serial_frame_parser_unpack_unit_assert.svh
`include "serial_frame_parser_unpack_unit_assert.svh"

module sfp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input sfp_pkg::out_item_t out_data
);
  import sfp_pkg::*;

  `SFP_ASSERT_RST(a_rst_empty, !out_valid)

  `SFP_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // an update only happens on the last byte of a frame, which also raises the link
  `SFP_ASSERT_NOW(a_accept_done, out_valid && out_data.frame_accepted, out_data.frame_done && out_data.link_alive)

  // if either count is cleared, both counts and the first and last values are cleared
  `SFP_ASSERT_NOW(a_count_range, out_valid && (out_data.count_a == 4'd0 || out_data.count_b == 4'd0), out_data.count_a == 4'd0 && out_data.count_b == 4'd0 && out_data.value_one == 16'sd0 && out_data.value_five == 16'sd0)

  `SFP_ASSERT_NOW(a_count_max, out_valid, out_data.count_a <= 4'd3 && out_data.count_b <= 4'd3)

endmodule

bind serial_frame_parser_unpack_unit sfp_checker u_sfp_checker (.*);
